>>> sv/wfs_pkg.sv
// ----------------------------------------------------------------------------
// wfs_pkg
// Shared types, constants and the CORDIC arctangent table for the
// wall-following steering block.
// ----------------------------------------------------------------------------
package wfs_pkg;

    localparam int unsigned MaxStages      = 24;
    localparam int unsigned DefStages      = 16;
    localparam int unsigned IdxW           = 3;
    localparam int unsigned DataW          = 16;

    localparam logic [IdxW-1:0] RegDesired = 3'd0;
    localparam logic [IdxW-1:0] RegGain    = 3'd1;
    localparam logic [IdxW-1:0] RegLook    = 3'd2;
    localparam logic [IdxW-1:0] RegSpeed   = 3'd3;
    localparam logic [IdxW-1:0] RegCos     = 3'd4;
    localparam logic [IdxW-1:0] RegSin     = 3'd5;

    localparam logic [1:0] StatusOk        = 2'd0;
    localparam logic [1:0] StatusUncovered = 2'd1;
    localparam logic [1:0] StatusInvalid   = 2'd2;

    // Vectoring values reach about 2^33 (Q15 mm times CORDIC gain).
    localparam int unsigned VecW           = 36;
    localparam int unsigned AngW           = 33;
    localparam int unsigned TrigW          = 33;
    localparam logic signed [TrigW-1:0] InvGainQ30 = 33'sd652032874;

    typedef struct packed {
        logic [15:0] range_side;
        logic [15:0] range_ahead;
        logic        side_finite;
        logic        ahead_finite;
        logic        angles_covered;
    } wfs_in_t;

    typedef struct packed {
        logic signed [15:0] steering;
        logic [15:0]        speed_out;
        logic [1:0]         status;
    } wfs_out_t;

    typedef struct packed {
        logic [IdxW-1:0] index;
        logic [15:0]     data;
    } wfs_cfg_t;

    function automatic logic signed [AngW-1:0] atan_q30(input logic [4:0] i);
        logic signed [AngW-1:0] r;
        unique case (i)
            5'd0:  r = 33'sd843314856;
            5'd1:  r = 33'sd497837829;
            5'd2:  r = 33'sd263043836;
            5'd3:  r = 33'sd133525158;
            5'd4:  r = 33'sd67021686;
            5'd5:  r = 33'sd33543515;
            5'd6:  r = 33'sd16775850;
            5'd7:  r = 33'sd8388437;
            5'd8:  r = 33'sd4194282;
            5'd9:  r = 33'sd2097149;
            5'd10: r = 33'sd1048575;
            5'd11: r = 33'sd524287;
            5'd12: r = 33'sd262143;
            5'd13: r = 33'sd131071;
            5'd14: r = 33'sd65535;
            5'd15: r = 33'sd32767;
            5'd16: r = 33'sd16383;
            5'd17: r = 33'sd8191;
            5'd18: r = 33'sd4095;
            5'd19: r = 33'sd2047;
            5'd20: r = 33'sd1023;
            5'd21: r = 33'sd511;
            5'd22: r = 33'sd255;
            5'd23: r = 33'sd127;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> sv/wfs_if.sv
// ----------------------------------------------------------------------------
// wfs_if
// Generic valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
interface wfs_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/wall_follow_steering.sv
// ----------------------------------------------------------------------------
// wall_follow_steering
// Two-beam wall-following proportional steering with pipelined CORDICs.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on in_ch (two ranges and three flags) and leave on out_ch
// (steering in milliradians, speed and a status code), one result per item.
// Registers are written on cfg_ch by index: 0 desired distance, 1 gain,
// 2 lookahead, 3 speed, 4 cos(phi), 5 sin(phi); other indexes are ignored.
// Registers should be written only while no item is in flight.
// The pipeline is 2*CORDIC_STAGES + 6 registers deep: the input products,
// the numerator and denominator, one stage per vectoring and per rotation
// iteration, then the distance products, the error, the gain product and
// the output stage with rounding. One item is taken every cycle while
// out_ch does not stall. When out_ch stalls the whole pipeline holds in
// place; in_ch ready falls only while the final stage holds an item that
// has not been taken.
// Reset empties the pipeline and loads the register reset values.
// ----------------------------------------------------------------------------
module wall_follow_steering
    import wfs_pkg::*;
#(
    parameter int unsigned CORDIC_STAGES = DefStages
)(
    input  logic  clk,
    input  logic  rst_n,
    wfs_if.sink   in_ch,
    wfs_if.source out_ch,
    wfs_if.sink   cfg_ch
);
    localparam int unsigned N = (CORDIC_STAGES > MaxStages) ? MaxStages :
                                ((CORDIC_STAGES < 1) ? 1 : CORDIC_STAGES);
    localparam int unsigned Depth = 2 * N + 6;

    logic [15:0] desired_reg, gain_reg, look_reg, speed_reg;
    logic [14:0] cos_reg, sin_reg;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desired_reg <= 16'd1000;
            gain_reg    <= 16'd205;
            look_reg    <= 16'd1000;
            speed_reg   <= 16'd20000;
            cos_reg     <= 15'd23170;
            sin_reg     <= 15'd23170;
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_ch.data.index)
                RegDesired: desired_reg <= cfg_ch.data.data;
                RegGain:    gain_reg    <= cfg_ch.data.data;
                RegLook:    look_reg    <= cfg_ch.data.data;
                RegSpeed:   speed_reg   <= cfg_ch.data.data;
                RegCos:     cos_reg     <= cfg_ch.data.data[14:0];
                RegSin:     sin_reg     <= cfg_ch.data.data[14:0];
                default: ;
            endcase
        end
    end

    // Global stall: everything advances when the output stage is free.
    logic adv;
    logic [Depth-1:0] vld_reg;
    assign adv         = !vld_reg[Depth-1] || out_ch.ready;
    assign in_ch.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[Depth-2:0], in_ch.valid};
    end

    // Per-item side data travels with the item.
    logic [15:0] side_reg [Depth];
    logic [1:0]  st_reg   [Depth];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= in_ch.data.range_side;
            st_reg[0]   <= !in_ch.data.angles_covered ? StatusUncovered :
                           (!(in_ch.data.side_finite && in_ch.data.ahead_finite) ?
                            StatusInvalid : StatusOk);
            for (int k = 1; k < Depth; k++)
            begin
                side_reg[k] <= side_reg[k-1];
                st_reg[k]   <= st_reg[k-1];
            end
        end
    end

    // Stage 0: products a*cos and a*sin.
    logic [30:0] acos_reg, asin_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            acos_reg <= 31'(in_ch.data.range_ahead * cos_reg);
            asin_reg <= 31'(in_ch.data.range_ahead * sin_reg);
        end
    end

    // Stage 1: numerator and denominator; the vectoring array starts here.
    logic signed [VecW-1:0] vx_reg [N+1];
    logic signed [VecW-1:0] vy_reg [N+1];
    logic signed [AngW-1:0] vz_reg [N+1];
    logic                   vzero_reg [N+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vx_reg[0]    <= VecW'($signed({1'b0, asin_reg}));
            vy_reg[0]    <= VecW'($signed({1'b0, acos_reg}))
                            - VecW'($signed({1'b0, side_reg[0], 15'd0}));
            vz_reg[0]    <= '0;
            vzero_reg[0] <= (VecW'($signed({1'b0, acos_reg}))
                            == VecW'($signed({1'b0, side_reg[0], 15'd0})));
        end
    end

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_vec
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    vzero_reg[g+1] <= vzero_reg[g];
                    if (vy_reg[g] >= 0)
                    begin
                        vx_reg[g+1] <= vx_reg[g] + (vy_reg[g] >>> g);
                        vy_reg[g+1] <= vy_reg[g] - (vx_reg[g] >>> g);
                        vz_reg[g+1] <= vz_reg[g] + atan_q30(5'(g));
                    end
                    else
                    begin
                        vx_reg[g+1] <= vx_reg[g] - (vy_reg[g] >>> g);
                        vy_reg[g+1] <= vy_reg[g] + (vx_reg[g] >>> g);
                        vz_reg[g+1] <= vz_reg[g] - atan_q30(5'(g));
                    end
                end
            end
        end
    endgenerate

    // Rotation array: cos and sin of alpha.
    logic signed [TrigW-1:0] rx_reg [N+1];
    logic signed [TrigW-1:0] ry_reg [N+1];
    logic signed [AngW-1:0]  rz_reg [N+1];

    always_comb
    begin
        rx_reg[0] = InvGainQ30;
        ry_reg[0] = '0;
        rz_reg[0] = vzero_reg[N] ? '0 : vz_reg[N];
    end

    generate
        for (g = 0; g < N; g++)
        begin : g_rot
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    if (rz_reg[g] >= 0)
                    begin
                        rx_reg[g+1] <= rx_reg[g] - (ry_reg[g] >>> g);
                        ry_reg[g+1] <= ry_reg[g] + (rx_reg[g] >>> g);
                        rz_reg[g+1] <= rz_reg[g] - atan_q30(5'(g));
                    end
                    else
                    begin
                        rx_reg[g+1] <= rx_reg[g] + (ry_reg[g] >>> g);
                        ry_reg[g+1] <= ry_reg[g] - (rx_reg[g] >>> g);
                        rz_reg[g+1] <= rz_reg[g] + atan_q30(5'(g));
                    end
                end
            end
        end
    endgenerate

    // Distance products (Q30 mm), then error and gain, then rounding.
    localparam int unsigned PW = 50;
    localparam int unsigned DW = 52;
    localparam int unsigned EW = 45;
    localparam int unsigned GW = 62;
    logic signed [PW-1:0] bc_reg, ls_reg;
    logic signed [EW-1:0] err_reg;
    logic signed [GW-1:0] prod_reg;
    logic signed [DW-1:0] dist_sum, errf;

    assign dist_sum = DW'(bc_reg) + DW'(ls_reg);
    assign errf     = $signed({4'd0, desired_reg, 32'd0}) >>> 2;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bc_reg   <= PW'($signed({1'b0, side_reg[2*N+1]}) * rx_reg[N]);
            ls_reg   <= PW'($signed({1'b0, look_reg}) * ry_reg[N]);
            err_reg  <= EW'((errf - dist_sum) >>> 8);
            prod_reg <= GW'(err_reg * $signed({1'b0, gain_reg}));
        end
    end

    logic signed [GW-1:0] rnd;
    logic signed [GW-31:0] sh;
    logic signed [15:0] steer;
    assign rnd = prod_reg + GW'(64'sd536870912);
    assign sh  = rnd[GW-1:30];
    always_comb
    begin
        if (sh > 32767)
            steer = 16'sd32767;
        else if (sh < -32768)
            steer = -16'sd32768;
        else
            steer = sh[15:0];
    end

    wfs_out_t res_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg.status    <= st_reg[Depth-2];
            res_reg.steering  <= (st_reg[Depth-2] == StatusOk) ? steer : '0;
            res_reg.speed_out <= (st_reg[Depth-2] == StatusOk) ? speed_reg : '0;
        end
    end

    assign out_ch.valid = vld_reg[Depth-1];
    assign out_ch.data  = res_reg;

endmodule

>>> tb/sv/wall_follow_steering_tb.sv
// ----------------------------------------------------------------------------
// wall_follow_steering_tb
// Self-checking bench for the wall-following steering block. Items are driven
// with random gaps and the output side stalls at random. Every item is
// predicted with a bit-exact CORDIC model and compared, in order, with the
// result that leaves the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wall_follow_steering_tb;
    import wfs_pkg::*;

    localparam int unsigned Stages    = DefStages;
    localparam int unsigned Latency   = 2 * Stages + 6;
    localparam int unsigned IdleLimit = 20000;
    localparam logic [IdxW-1:0] RegNone = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    wfs_if #(.T(wfs_in_t))  in_ch ();
    wfs_if #(.T(wfs_out_t)) out_ch ();
    wfs_if #(.T(wfs_cfg_t)) cfg_ch ();

    wall_follow_steering #(.CORDIC_STAGES(Stages)) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg_ch (cfg_ch.sink)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Register copies used by the predictor.
    logic [15:0] desired_mm, gain_q8, look_mm, speed_mm;
    logic [14:0] cos_phi, sin_phi;

    wfs_out_t    steer_queue[$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          items_sent = 0;
    int          idle_cycles = 0;
    bit          stall_on = 1'b1;
    bit          hold_off = 1'b0;
    bit          drive_gaps = 1'b1;
    logic signed [63:0] atan_tab[24];

    initial
    begin
        atan_tab = '{64'sd843314856, 64'sd497837829, 64'sd263043836, 64'sd133525158,
                     64'sd67021686, 64'sd33543515, 64'sd16775850, 64'sd8388437,
                     64'sd4194282, 64'sd2097149, 64'sd1048575, 64'sd524287,
                     64'sd262143, 64'sd131071, 64'sd65535, 64'sd32767, 64'sd16383,
                     64'sd8191, 64'sd4095, 64'sd2047, 64'sd1023, 64'sd511,
                     64'sd255, 64'sd127};
    end

    function automatic wfs_out_t predict_steering(wfs_in_t item);
        wfs_out_t r;
        logic signed [63:0] b, a, x, y, z, dx, dy, c, s, dist_q30, err, prod, steer;
        b = item.range_side;
        a = item.range_ahead;
        r = '0;
        if (!item.angles_covered)
        begin
            r.status = StatusUncovered;
            return r;
        end
        if (!item.side_finite || !item.ahead_finite)
        begin
            r.status = StatusInvalid;
            return r;
        end
        y = a * cos_phi - b * 32768;
        x = a * sin_phi;
        z = 0;
        // A zero numerator gives a level wall without any CORDIC iteration.
        if (y != 0)
            for (int i = 0; i < Stages; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0)
                begin
                    x += dx; y -= dy; z += atan_tab[i];
                end
                else
                begin
                    x -= dx; y += dy; z -= atan_tab[i];
                end
            end
        x = 64'sd652032874;
        y = 0;
        for (int i = 0; i < Stages; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= atan_tab[i];
            end
            else
            begin
                x += dx; y -= dy; z += atan_tab[i];
            end
        end
        c = x;
        s = y;
        dist_q30 = b * c + $signed({48'd0, look_mm}) * s;
        err = $signed({48'd0, desired_mm}) * 64'sd1073741824 - dist_q30;
        prod = (err >>> 8) * $signed({48'd0, gain_q8});
        steer = (prod + 64'sd536870912) >>> 30;
        if (steer > 32767)
            steer = 32767;
        if (steer < -32768)
            steer = -32768;
        r.steering = steer[15:0];
        r.speed_out = speed_mm;
        r.status = StatusOk;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
                 results_seen);
    endtask

    // Output side: random stalls, a long hold-off on request, and checking.
    initial
    begin
        int held;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_ch.ready = 1'b0;
                held = 0;
                while (held < 3 * Latency)
                begin
                    @(negedge clk);
                    held++;
                end
                hold_off = 1'b0;
            end
            out_ch.ready = stall_on ? ($urandom_range(99) >= 26) : 1'b1;
        end
    end

    always @(posedge clk)
    begin
        wfs_out_t want, got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.data;
            if (steer_queue.size() == 0)
                report_mismatch("unexpected result", got.status, -1);
            else
            begin
                want = steer_queue.pop_front();
                if (got.steering !== want.steering)
                    report_mismatch("steering", got.steering, want.steering);
                if (got.speed_out !== want.speed_out)
                    report_mismatch("speed_out", got.speed_out, want.speed_out);
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
            end
            results_seen++;
        end
    end

    // Watchdog on cycles without a handshake on any channel.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IdleLimit)
        begin
            $display("FAIL wall_follow_steering");
            $finish;
        end
    end

    // Valid stays high after an item so that the next one can follow at once.
    task automatic send_ranges(wfs_in_t item);
        while (drive_gaps && $urandom_range(99) < 26)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.data  <= item;
        in_ch.valid <= 1'b1;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        steer_queue.push_back(predict_steering(item));
        items_sent++;
        @(negedge clk);
    endtask

    task automatic drain_pipeline();
        in_ch.valid <= 1'b0;
        while (steer_queue.size() != 0)
            @(negedge clk);
        repeat (Latency + 4) @(negedge clk);
    endtask

    task automatic write_register(logic [IdxW-1:0] index, logic [15:0] value);
        cfg_ch.data  <= '{index: index, data: value};
        cfg_ch.valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        case (index)
            RegDesired: desired_mm = value;
            RegGain:    gain_q8 = value;
            RegLook:    look_mm = value;
            RegSpeed:   speed_mm = value;
            RegCos:     cos_phi = value[14:0];
            RegSin:     sin_phi = value[14:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    function automatic wfs_in_t random_ranges(int valid_pct);
        wfs_in_t item;
        item.range_side  = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(8000));
        item.range_ahead = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(8000));
        item.angles_covered = ($urandom_range(99) < valid_pct + 10);
        item.side_finite    = ($urandom_range(99) < valid_pct + 10);
        item.ahead_finite   = ($urandom_range(99) < valid_pct + 10);
        return item;
    endfunction

    task automatic test_directed();
        logic [15:0] edges[4] = '{16'd0, 16'd1, 16'd1000, 16'hFFFF};
        foreach (edges[i])
            foreach (edges[j])
                send_ranges('{edges[i], edges[j], 1'b1, 1'b1, 1'b1});
        // Uncovered beams win over invalid ranges.
        send_ranges('{16'd500, 16'd700, 1'b0, 1'b0, 1'b0});
        send_ranges('{16'd500, 16'd700, 1'b1, 1'b1, 1'b0});
        send_ranges('{16'd500, 16'd700, 1'b0, 1'b1, 1'b1});
        send_ranges('{16'd500, 16'd700, 1'b1, 1'b0, 1'b1});
        drain_pipeline();
    endtask

    task automatic test_register_extremes();
        // Zero sine gives a zero denominator; zero cosine, max values saturate.
        write_register(RegSin, 16'd0);
        send_ranges('{16'd1000, 16'd2000, 1'b1, 1'b1, 1'b1});
        send_ranges('{16'd0, 16'd0, 1'b1, 1'b1, 1'b1});
        send_ranges('{16'd3000, 16'd10, 1'b1, 1'b1, 1'b1});
        drain_pipeline();
        write_register(RegSin, 16'hFFFF);
        write_register(RegCos, 16'd0);
        write_register(RegGain, 16'hFFFF);
        write_register(RegDesired, 16'hFFFF);
        write_register(RegLook, 16'hFFFF);
        write_register(RegSpeed, 16'hFFFF);
        write_register(RegNone, 16'h1234);
        for (int i = 0; i < 40; i++)
            send_ranges(random_ranges(90));
        drain_pipeline();
        write_register(RegGain, 16'd0);
        write_register(RegDesired, 16'd0);
        write_register(RegLook, 16'd0);
        write_register(RegSpeed, 16'd0);
        write_register(RegCos, 16'h7FFF);
        write_register(RegSin, 16'd1);
        for (int i = 0; i < 40; i++)
            send_ranges(random_ranges(90));
        drain_pipeline();
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 8; phase++)
        begin
            write_register(RegDesired, 16'($urandom_range(3000)));
            write_register(RegGain, 16'($urandom));
            write_register(RegLook, 16'($urandom_range(4000)));
            write_register(RegSpeed, 16'($urandom));
            write_register(RegCos, 16'($urandom));
            write_register(RegSin, 16'($urandom_range(32767, 1)));
            for (int i = 0; i < 90; i++)
                send_ranges(random_ranges(85));
            drain_pipeline();
        end
    endtask

    task automatic test_backpressure();
        // The receiver holds off while the sender keeps offering items.
        drive_gaps = 1'b0;
        hold_off = 1'b1;
        for (int i = 0; i < 60; i++)
            send_ranges(random_ranges(90));
        drain_pipeline();
        // No idling on either side.
        stall_on = 1'b0;
        for (int i = 0; i < 60; i++)
            send_ranges(random_ranges(90));
        drain_pipeline();
        stall_on = 1'b1;
        drive_gaps = 1'b1;
    endtask

    initial
    begin
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        desired_mm = 16'd1000;
        gain_q8    = 16'd205;
        look_mm    = 16'd1000;
        speed_mm   = 16'd20000;
        cos_phi    = 15'd23170;
        sin_phi    = 15'd23170;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_register_extremes();
        test_backpressure();
        test_random_settings();
        $display("Sent %0d items over twelve register settings, checked %0d results.",
                 items_sent, results_seen);
        $display("Covered flag priority, zero denominators, saturation and stalls.");
        if (mismatches == 0)
            $display("PASS wall_follow_steering");
        else
            $display("FAIL wall_follow_steering");
        $finish;
    end

endmodule
